// ----- rtl/core/ps2mt_pkg.sv -----
// ----------------------------------------------------------------------------
// ps2mt_pkg
// Shared types, codes and helpers for the PS/2 mouse packet tracker.
// ----------------------------------------------------------------------------
package ps2mt_pkg;

  // Stored cursor width
  localparam int POS_WIDTH = 16;
  // Field widths fixed by the interface
  localparam int REG_W     = 16;
  localparam int OUT_POS_W = 16;
  localparam int BYTE_W    = 8;
  localparam int BTN_W     = 3;
  localparam int CFG_IDX_W = 2;

  // Working width for clamp and delta math: wide enough for the clamp
  // registers and the stored cursor, plus headroom for one add
  localparam int EXT_W = ((POS_WIDTH > REG_W) ? POS_WIDTH : REG_W) + 2;

  localparam logic signed [EXT_W-1:0] POS_MAX = EXT_W'((64'sd1 <<< (POS_WIDTH - 1)) - 64'sd1);
  localparam logic signed [EXT_W-1:0] POS_MIN = -POS_MAX - EXT_W'(1);

  localparam logic [REG_W-1:0] MIN_Y_RESET = REG_W'(12);

  // Position of the next byte within a packet
  typedef enum logic [1:0] {
    PH_BTN = 2'd0,
    PH_DX  = 2'd1,
    PH_DY  = 2'd2
  } phase_t;

  typedef enum logic {
    EV_EDGE = 1'b0,
    EV_MOVE = 1'b1
  } ev_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLICK_EN = 2'd0,
    CFG_MOVE_EN  = 2'd1,
    CFG_MIN_X    = 2'd2,
    CFG_MIN_Y    = 2'd3
  } cfg_idx_t;

  // Saturate a working-width value into the stored cursor width
  function automatic logic [POS_WIDTH-1:0] sat_pos(input logic signed [EXT_W-1:0] v);
    logic [POS_WIDTH-1:0] r;
    if (v > POS_MAX) begin
      r = POS_MAX[POS_WIDTH-1:0];
    end else if (v < POS_MIN) begin
      r = POS_MIN[POS_WIDTH-1:0];
    end else begin
      r = v[POS_WIDTH-1:0];
    end
    return r;
  endfunction

  // Sign-extend a stored cursor value to the working width
  function automatic logic signed [EXT_W-1:0] ext_pos(input logic [POS_WIDTH-1:0] p);
    return EXT_W'($signed(p));
  endfunction

  // Sign-extend a clamp register to the working width
  function automatic logic signed [EXT_W-1:0] ext_reg(input logic [REG_W-1:0] p);
    return EXT_W'($signed(p));
  endfunction

  // Reported position: low bits of the sign-extended stored value
  function automatic logic [OUT_POS_W-1:0] rep_pos(input logic [POS_WIDTH-1:0] p);
    logic signed [EXT_W-1:0] e;
    e = EXT_W'($signed(p));
    return e[OUT_POS_W-1:0];
  endfunction

endpackage

// ----- rtl/core/ps2_mouse_packet_tracker_top.sv -----
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker_top
// Groups PS/2 mouse bytes into packets, tracks the cursor, reports events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_rx_byte) carries one received
//   mouse byte per beat. Bytes are taken as packets of three by position:
//   buttons, x delta, y delta. The result channel (out_valid / out_stall /
//   out_*) carries at most one event per byte: a button edge event on a
//   button byte (click reporting on) or a move event on a y-delta byte
//   (move reporting on). Other bytes produce no beat.
//   Pipeline: input register -> update logic -> output register. An accepted
//   byte waits in the input register until the output register is free; it
//   is then processed and its event, if any, loads the output register.
//   Throughput: one byte per cycle, bounded by the single output register.
//   While a result waits under out_stall, one more byte is still taken into
//   the input register; after that in_stall rises until the result drains.
//   Configuration: cfg_we / cfg_index / cfg_wdata, written while idle.
//   Reset (rst_n low, synchronous): both channels empty, packet position
//   at the button byte, cursor at zero, no button held, reporting off,
//   min_x = 0, min_y = 12.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_we,
  input  logic [ps2mt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ps2mt_pkg::REG_W-1:0]     cfg_wdata,
  // byte input
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [ps2mt_pkg::BYTE_W-1:0]    in_rx_byte,
  // event output
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_event_kind,
  output logic [ps2mt_pkg::OUT_POS_W-1:0] out_pos_x,
  output logic [ps2mt_pkg::OUT_POS_W-1:0] out_pos_y,
  output logic                            out_pressed,
  output logic [ps2mt_pkg::BTN_W-1:0]     out_buttons
);

  // configuration registers
  logic                        click_en_r;
  logic                        move_en_r;
  logic [ps2mt_pkg::REG_W-1:0] min_x_r;
  logic [ps2mt_pkg::REG_W-1:0] min_y_r;

  // input register
  logic                         in_vld_r;
  logic [ps2mt_pkg::BYTE_W-1:0] in_byte_r;

  // tracker state
  ps2mt_pkg::phase_t                phase_r, phase_nxt;
  logic [ps2mt_pkg::BYTE_W-1:0]     dx_r, dx_nxt;
  logic [ps2mt_pkg::POS_WIDTH-1:0]  cur_x_r, cur_x_nxt;
  logic [ps2mt_pkg::POS_WIDTH-1:0]  cur_y_r, cur_y_nxt;
  logic                             held_r, held_nxt;
  logic [ps2mt_pkg::BTN_W-1:0]      btn_r, btn_nxt;

  // output register
  logic                            out_valid_r;
  ps2mt_pkg::ev_kind_t             out_kind_r;
  logic [ps2mt_pkg::OUT_POS_W-1:0] out_x_r, out_y_r;
  logic                            out_pressed_r;
  logic [ps2mt_pkg::BTN_W-1:0]     out_btn_r;

  // event built for the byte in the input register
  logic                 ev_fire;
  ps2mt_pkg::ev_kind_t  ev_kind;
  logic                 ev_pressed;

  logic adv;   // output register can load this cycle
  logic proc;  // byte in the input register is processed this cycle

  logic                               any_btn;
  logic signed [ps2mt_pkg::EXT_W-1:0] clamp_x, clamp_y;

  assign adv      = !out_valid_r || !out_stall;
  assign proc     = in_vld_r && adv;
  assign in_stall = in_vld_r && !adv;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      click_en_r <= 1'b0;
      move_en_r  <= 1'b0;
      min_x_r    <= '0;
      min_y_r    <= ps2mt_pkg::MIN_Y_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ps2mt_pkg::CFG_CLICK_EN: click_en_r <= cfg_wdata[0];
        ps2mt_pkg::CFG_MOVE_EN:  move_en_r  <= cfg_wdata[0];
        ps2mt_pkg::CFG_MIN_X:    min_x_r    <= cfg_wdata;
        ps2mt_pkg::CFG_MIN_Y:    min_y_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_vld_r <= 1'b1;
    end else if (proc) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_rx_byte;
    end
  end

  // per-byte update
  always_comb begin
    phase_nxt  = phase_r;
    dx_nxt     = dx_r;
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    held_nxt   = held_r;
    btn_nxt    = btn_r;
    ev_fire    = 1'b0;
    ev_kind    = ps2mt_pkg::EV_EDGE;
    ev_pressed = 1'b0;
    any_btn    = 1'b0;
    clamp_x    = ps2mt_pkg::ext_pos(cur_x_r);
    clamp_y    = ps2mt_pkg::ext_pos(cur_y_r);

    case (phase_r)
      ps2mt_pkg::PH_DX: begin
        dx_nxt    = in_byte_r;
        phase_nxt = ps2mt_pkg::PH_DY;
      end
      ps2mt_pkg::PH_DY: begin
        // report the position before the update
        ev_fire = move_en_r;
        ev_kind = ps2mt_pkg::EV_MOVE;
        // clamp to the minimum first, then apply the deltas
        if (clamp_x < ps2mt_pkg::ext_reg(min_x_r)) begin
          clamp_x = ps2mt_pkg::ext_pos(ps2mt_pkg::sat_pos(ps2mt_pkg::ext_reg(min_x_r)));
        end
        if (clamp_y < ps2mt_pkg::ext_reg(min_y_r)) begin
          clamp_y = ps2mt_pkg::ext_pos(ps2mt_pkg::sat_pos(ps2mt_pkg::ext_reg(min_y_r)));
        end
        cur_x_nxt = ps2mt_pkg::sat_pos(clamp_x + ps2mt_pkg::EXT_W'($signed(dx_r)));
        cur_y_nxt = ps2mt_pkg::sat_pos(clamp_y - ps2mt_pkg::EXT_W'($signed(in_byte_r)));
        phase_nxt = ps2mt_pkg::PH_BTN;
      end
      default: begin
        // button byte; the unused phase code is treated the same way
        btn_nxt = in_byte_r[ps2mt_pkg::BTN_W-1:0];
        any_btn = |btn_nxt;
        if (click_en_r && (held_r != any_btn)) begin
          held_nxt   = any_btn;
          ev_fire    = 1'b1;
          ev_kind    = ps2mt_pkg::EV_EDGE;
          ev_pressed = any_btn;
        end
        phase_nxt = ps2mt_pkg::PH_DX;
      end
    endcase
  end

  // tracker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ps2mt_pkg::PH_BTN;
      dx_r    <= '0;
      cur_x_r <= '0;
      cur_y_r <= '0;
      held_r  <= 1'b0;
      btn_r   <= '0;
    end else if (proc) begin
      phase_r <= phase_nxt;
      dx_r    <= dx_nxt;
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
      held_r  <= held_nxt;
      btn_r   <= btn_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= proc && ev_fire;
    end
  end

  // events carry the pre-update cursor and the latest button bits
  always_ff @(posedge clk) begin
    if (proc && ev_fire) begin
      out_kind_r    <= ev_kind;
      out_x_r       <= ps2mt_pkg::rep_pos(cur_x_r);
      out_y_r       <= ps2mt_pkg::rep_pos(cur_y_r);
      out_pressed_r <= ev_pressed;
      out_btn_r     <= btn_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_kind = out_kind_r;
  assign out_pos_x      = out_x_r;
  assign out_pos_y      = out_y_r;
  assign out_pressed    = out_pressed_r;
  assign out_buttons    = out_btn_r;

  // assertions
  a_move_on_dy: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && ev_fire && ev_kind == ps2mt_pkg::EV_MOVE) |-> phase_r == ps2mt_pkg::PH_DY)
    else $error("move event outside y-delta byte");

  a_dx_then_dy: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && phase_r == ps2mt_pkg::PH_DX) |=> phase_r == ps2mt_pkg::PH_DY)
    else $error("packet position did not advance after x delta");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_vld_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked result");

  a_held_edge: assert property (@(posedge clk) disable iff (!rst_n)
    (held_r != $past(held_r)) |-> (out_valid_r && out_kind_r == ps2mt_pkg::EV_EDGE
                                   && out_pressed_r == held_r))
    else $error("held flag changed without an edge event");

endmodule
